[design/tcst_pkg.sv]
// Package for the TCP connection state tracker: table geometry, state and outcome codes,
// and the flag transition function. No dependencies.
package tcst_pkg;
    localparam int Capacity = 256;
    localparam int IdxW = $clog2(Capacity);
    localparam int KeyW = 96;

    localparam logic [2:0] ST_SYN_SEEN    = 3'd0;
    localparam logic [2:0] ST_SYN_RECV    = 3'd1;
    localparam logic [2:0] ST_ESTABLISHED = 3'd2;
    localparam logic [2:0] ST_FIN_SENT    = 3'd3;
    localparam logic [2:0] ST_FIN_ACKED   = 3'd4;
    localparam logic [2:0] ST_PEER_FIN    = 3'd5;
    localparam logic [2:0] ST_CLOSE       = 3'd6;

    localparam logic [2:0] OC_UNTRACKED = 3'd0;
    localparam logic [2:0] OC_CREATED   = 3'd1;
    localparam logic [2:0] OC_FULL      = 3'd2;
    localparam logic [2:0] OC_TRANS     = 3'd3;
    localparam logic [2:0] OC_UNCHANGED = 3'd4;
    localparam logic [2:0] OC_RST_REM   = 3'd5;
    localparam logic [2:0] OC_CLOSE_REM = 3'd6;

    typedef struct packed {
        logic [2:0] state;
        logic [3:0] backend;
    } t_entry;

    function automatic logic [2:0] next_state(input logic [2:0] s, input logic syn,
                                              input logic ack, input logic fin);
        logic [2:0] r;
        r = s;
        if (s == ST_SYN_RECV && ack) begin
            r = ST_ESTABLISHED;
        end else if (s == ST_ESTABLISHED && fin) begin
            r = ST_FIN_SENT;
        end else if (s == ST_FIN_ACKED && ack) begin
            r = ST_CLOSE;
        end else if (s == ST_SYN_SEEN && syn && ack) begin
            r = ST_SYN_RECV;
        end else begin
            if (r == ST_FIN_SENT && ack) begin
                r = ST_PEER_FIN;
            end
            if (r == ST_PEER_FIN && fin && ack) begin
                r = ST_FIN_ACKED;
            end
        end
        return r;
    endfunction
endpackage

[design/tcst_table.sv]
// Connection table storage: key memory, entry memory (registered read) and valid bits.
// Depends on tcst_pkg.
module tcst_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [tcst_pkg::IdxW-1:0]  i_rd_addr,
    output logic [tcst_pkg::KeyW-1:0]  o_rd_key,
    output tcst_pkg::t_entry           o_rd_entry,
    output logic                       o_rd_valid,
    input  logic                       i_wr_en,
    input  logic [tcst_pkg::IdxW-1:0]  i_wr_addr,
    input  logic [tcst_pkg::KeyW-1:0]  i_wr_key,
    input  logic                       i_wr_key_en,
    input  tcst_pkg::t_entry           i_wr_entry,
    input  logic                       i_wr_valid
);
    logic [tcst_pkg::KeyW-1:0] r_key_mem [tcst_pkg::Capacity];
    tcst_pkg::t_entry          r_ent_mem [tcst_pkg::Capacity];
    logic [tcst_pkg::Capacity-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_key_en) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
        end
        if (i_wr_en) begin
            r_ent_mem[i_wr_addr] <= i_wr_entry;
        end
        o_rd_key   <= r_key_mem[i_rd_addr];
        o_rd_entry <= r_ent_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            o_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= i_wr_valid;
            end
            o_rd_valid <= r_valid[i_rd_addr];
        end
    end
endmodule

[design/tcp_connection_state_tracker.sv]
// Top level of the TCP connection state tracker: control sequencer around the table.
// Depends on tcst_pkg and tcst_table.
//
// Usage: one packet header is transferred on the input channel (i_valid / o_stall).
// The block then sweeps every table entry, one per cycle, reading key, state and
// backend id from a memory with a registered read port, and compares each valid
// entry against the forward and the swapped four-tuple. It remembers the lowest
// forward hit, the lowest reverse hit and the lowest free entry. After the sweep,
// the done state applies the update (insert, transition or removal) to the table
// and loads the result into an output register shown with o_valid.
// The sweep walks the single memory read port of the table; one packet is processed
// at a time, and the next header can be taken while the previous result still
// waits in the output register.
// Non-TCP packets skip the sweep and go straight to the done state.
// When the receiver holds i_stall, the result stays on the outputs unchanged and a
// new result is not written until the old one has been transferred.
// Reset clears all valid marks at once, the round-robin counter to zero and the
// backend count register to 6. The backend count is written on the cfg channel,
// always ready; write it only while the block is idle, which is not enforced.
module tcp_connection_state_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_is_tcp,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic        i_flag_syn,
    input  logic        i_flag_ack,
    input  logic        i_flag_fin,
    input  logic        i_flag_rst,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_outcome,
    output logic [2:0]  o_conn_state_out,
    output logic [3:0]  o_backend_id,
    output logic        o_matched_reverse
);
    localparam int IW = tcst_pkg::IdxW;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]  r_state;
    logic [IW:0] r_rd_cnt;   // read address counter, one wider to mark the end
    logic [IW-1:0] r_cmp_cnt;  // index of the data coming back from memory
    logic        r_cmp_vld;
    logic [95:0] r_key, r_rkey;
    logic        r_tcp, r_syn, r_ack, r_fin, r_rst;
    logic        r_fhit, r_rhit, r_free;
    logic [IW-1:0] r_fidx, r_ridx, r_fridx;
    tcst_pkg::t_entry r_fent, r_rent;
    logic [3:0]  r_rr, r_bcount;

    logic [tcst_pkg::KeyW-1:0] rd_key;
    tcst_pkg::t_entry rd_ent;
    logic        rd_valid;
    logic        wr_en, wr_key_en, wr_valid;
    logic [IW-1:0] wr_addr;
    tcst_pkg::t_entry wr_ent;

    logic        in_acc, out_free;
    logic [2:0]  n_outcome, n_st;
    logic [3:0]  n_bid, n_rr;
    logic        n_rev;

    assign o_cfg_ready = 1'b1;
    assign o_stall = (r_state != S_IDLE);
    assign in_acc = i_valid && !o_stall;
    assign out_free = !o_valid || !i_stall;

    tcst_table u_table (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_rd_addr(r_rd_cnt[IW-1:0]),
        .o_rd_key(rd_key), .o_rd_entry(rd_ent), .o_rd_valid(rd_valid),
        .i_wr_en(wr_en), .i_wr_addr(wr_addr), .i_wr_key(r_key),
        .i_wr_key_en(wr_key_en), .i_wr_entry(wr_ent), .i_wr_valid(wr_valid)
    );

    // Decision after the sweep; forward hits win over reverse hits.
    always_comb begin
        logic          hit;
        logic [IW-1:0] hidx;
        tcst_pkg::t_entry hent;
        logic [2:0]    ns;
        logic [3:0]    rr0;
        hit = r_fhit || r_rhit;
        hidx = r_fhit ? r_fidx : r_ridx;
        hent = r_fhit ? r_fent : r_rent;
        ns = tcst_pkg::next_state(hent.state, r_syn, r_ack, r_fin);
        rr0 = (r_rr >= r_bcount) ? 4'd0 : r_rr;
        n_rr = r_rr;
        n_outcome = tcst_pkg::OC_UNTRACKED;
        n_st = tcst_pkg::ST_SYN_SEEN;
        n_bid = 4'd0;
        n_rev = 1'b0;
        wr_en = 1'b0;
        wr_key_en = 1'b0;
        wr_valid = 1'b0;
        wr_addr = hidx;
        wr_ent = hent;
        if (r_state == S_DONE && out_free && r_tcp) begin
            if (hit) begin
                n_bid = hent.backend;
                n_rev = !r_fhit;
                wr_en = 1'b1;
                if (r_rst) begin
                    n_outcome = tcst_pkg::OC_RST_REM;
                    n_st = hent.state;
                end else begin
                    n_st = ns;
                    wr_ent.state = ns;
                    if (ns == tcst_pkg::ST_CLOSE) begin
                        n_outcome = tcst_pkg::OC_CLOSE_REM;
                    end else begin
                        wr_valid = 1'b1;
                        n_outcome = (ns != hent.state) ? tcst_pkg::OC_TRANS
                                                       : tcst_pkg::OC_UNCHANGED;
                    end
                end
            end else if (r_syn && !r_ack) begin
                n_rr = rr0 + 4'd1;
                if (r_free) begin
                    n_outcome = tcst_pkg::OC_CREATED;
                    n_bid = n_rr;
                    wr_en = 1'b1;
                    wr_key_en = 1'b1;
                    wr_valid = 1'b1;
                    wr_addr = r_fridx;
                    wr_ent.state = tcst_pkg::ST_SYN_SEEN;
                    wr_ent.backend = n_rr;
                end else begin
                    n_outcome = tcst_pkg::OC_FULL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd_cnt <= '0;
            r_cmp_vld <= 1'b0;
            o_valid <= 1'b0;
            r_rr <= 4'd0;
            r_bcount <= 4'd6;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_bcount <= i_cfg_data;
            end
            // A new result replaces the old one only once that has been transferred.
            if (r_state == S_DONE && out_free) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            r_cmp_vld <= (r_state == S_SCAN) && !r_rd_cnt[IW];
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_rd_cnt <= '0;
                        r_state <= i_is_tcp ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN: begin
                    if (!r_rd_cnt[IW]) begin
                        r_rd_cnt <= r_rd_cnt + 1'b1;
                    end else if (!r_cmp_vld) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_rr <= n_rr;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload, sweep bookkeeping and the output result registers.
    always_ff @(posedge i_clk) begin
        r_cmp_cnt <= r_rd_cnt[IW-1:0];
        if (in_acc) begin
            r_key  <= {i_src_addr, i_dst_addr, i_src_port, i_dst_port};
            r_rkey <= {i_dst_addr, i_src_addr, i_dst_port, i_src_port};
            r_tcp <= i_is_tcp;
            r_syn <= i_flag_syn;
            r_ack <= i_flag_ack;
            r_fin <= i_flag_fin;
            r_rst <= i_flag_rst;
            r_fhit <= 1'b0;
            r_rhit <= 1'b0;
            r_free <= 1'b0;
        end else if (r_cmp_vld) begin
            if (rd_valid && rd_key == r_key && !r_fhit) begin
                r_fhit <= 1'b1;
                r_fidx <= r_cmp_cnt;
                r_fent <= rd_ent;
            end
            if (rd_valid && rd_key == r_rkey && !r_rhit) begin
                r_rhit <= 1'b1;
                r_ridx <= r_cmp_cnt;
                r_rent <= rd_ent;
            end
            if (!rd_valid && !r_free) begin
                r_free <= 1'b1;
                r_fridx <= r_cmp_cnt;
            end
        end
        if (r_state == S_DONE && out_free) begin
            o_outcome <= n_outcome;
            o_conn_state_out <= n_st;
            o_backend_id <= n_bid;
            o_matched_reverse <= n_rev;
        end
    end

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> o_stall) else $error("input open during sweep");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_outcome)))
        else $error("result changed while stalled");
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_DONE)) else $error("table write outside update");
    a_rr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_outcome == tcst_pkg::OC_CREATED) |-> (n_bid != 4'd0))
        else $error("created entry without backend");
endmodule
